// File: sv/fdmp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Framed decimal message parser package
// Shared constants, register map and result types for the frame parser.
// ----------------------------------------------------------------------------
package fdmp_pkg;

    localparam int BUFFER_DIGITS = 4;

    localparam int RX_BYTE_W = 8;
    localparam int VALUE_W   = 14;
    localparam int DIGITS_W  = 3;
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 24;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_ADDR_W-1:0] ADDR_MAX_DIGITS = 3'd0;
    localparam logic [DIGITS_W-1:0]   MAX_DIGITS_RESET = 3'd4;

    localparam logic [RX_BYTE_W-1:0] CH_START = 8'h40;
    localparam logic [RX_BYTE_W-1:0] CH_END   = 8'h24;
    localparam logic [RX_BYTE_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [RX_BYTE_W-1:0] CH_NINE  = 8'h39;

    typedef struct packed {
        logic [DIGITS_W-1:0] frame_digits;
        logic [VALUE_W-1:0]  frame_value;
    } fdmp_result_t;

    typedef struct packed {
        logic                in_frame;
        logic [DIGITS_W-1:0] digit_count;
    } fdmp_status_t;

endpackage : fdmp_pkg
`default_nettype wire

// File: sv/fdmp_parser.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Frame parser stage
// Registers each received byte, then updates the frame state and forms a
// result when a terminator closes a frame holding at least one digit.
// ----------------------------------------------------------------------------
module fdmp_parser
    import fdmp_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [RX_BYTE_W-1:0] rx_byte,
    input  wire logic [DIGITS_W-1:0]  digit_limit,
    input  wire logic                 out_free,
    output logic                      res_valid,
    output fdmp_result_t              res,
    output fdmp_status_t              status
);

    logic                 in_valid_reg;
    logic [RX_BYTE_W-1:0] in_byte_reg;
    logic                 in_frame_reg;
    logic                 in_frame_next;
    logic [DIGITS_W-1:0]  count_reg;
    logic [DIGITS_W-1:0]  count_next;
    logic [VALUE_W-1:0]   accum_reg;
    logic [VALUE_W-1:0]   accum_next;
    logic                 is_digit;
    logic                 emit;
    logic                 advance;
    logic [VALUE_W-1:0]   digit_val;

    assign is_digit  = (in_byte_reg >= CH_ZERO) && (in_byte_reg <= CH_NINE);
    assign digit_val = VALUE_W'(in_byte_reg - CH_ZERO);
    assign emit      = in_frame_reg && (in_byte_reg == CH_END) && (count_reg != '0);
    assign advance   = in_valid_reg && (!emit || out_free);
    assign s_tready  = !in_valid_reg || advance;
    assign res_valid = in_valid_reg && emit && out_free;
    assign res       = '{frame_digits: count_reg, frame_value: accum_reg};
    assign status    = '{in_frame: in_frame_reg, digit_count: count_reg};

    always_comb
    begin
        in_frame_next = in_frame_reg;
        count_next    = count_reg;
        accum_next    = accum_reg;
        if (in_frame_reg)
        begin
            if (emit || !is_digit)
            begin
                in_frame_next = 1'b0;
                count_next    = '0;
                accum_next    = '0;
            end
            else if (count_reg < digit_limit)
            begin
                accum_next = (accum_reg << 3) + (accum_reg << 1) + digit_val;
                count_next = count_reg + 1'b1;
            end
        end
        if (in_byte_reg == CH_START)
        begin
            in_frame_next = 1'b1;
            count_next    = '0;
            accum_next    = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            in_frame_reg <= 1'b0;
            count_reg    <= '0;
            accum_reg    <= '0;
        end
        else
        begin
            if (advance)
            begin
                in_frame_reg <= in_frame_next;
                count_reg    <= count_next;
                accum_reg    <= accum_next;
            end
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_byte_reg <= rx_byte;
        end
    end

endmodule : fdmp_parser
`default_nettype wire

// File: sv/fdmp_result_reg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Result register
// Holds one completed frame until the downstream side takes the transaction.
// ----------------------------------------------------------------------------
module fdmp_result_reg
    import fdmp_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 res_valid,
    input  wire fdmp_result_t         res,
    output logic                      out_free,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_TDATA_W-1:0]      m_tdata
);

    logic         valid_reg;
    fdmp_result_t data_reg;

    assign out_free = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign m_tdata  = M_TDATA_W'(data_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && res_valid)
        begin
            data_reg <= res;
        end
    end

endmodule : fdmp_result_reg
`default_nettype wire

// File: sv/framed_decimal_message_parser_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Framed decimal message parser core
// Parses '@' digits '$' frames from a byte stream into a decimal value and
// its digit count, with the digit limit set through an APB register.
// ----------------------------------------------------------------------------
// Datapath: a byte is registered, then parsed into the result register,
// which holds the result transaction for the downstream side.
// Throughput: one byte per cycle, limited only by the result register when
// the downstream side stalls.
// Reset: asynchronous, active low; clears the frame state and the digit
// limit returns to four.
module framed_decimal_message_parser_core
    import fdmp_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [S_TDATA_W-1:0]  s_tdata,   // [7:0] rx_byte
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [M_TDATA_W-1:0]       m_tdata,   // [13:0] frame_value, [16:14] frame_digits
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0]      prdata,
    output logic                       pready
);

    logic [DIGITS_W-1:0] max_digits_reg;
    logic [DIGITS_W-1:0] digit_limit;
    logic                out_free;
    logic                res_valid;
    fdmp_result_t        res;
    fdmp_status_t        status;

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_MAX_DIGITS) ? CFG_DATA_W'(max_digits_reg) : '0;

    assign digit_limit = (32'(max_digits_reg) > BUFFER_DIGITS) ?
                         DIGITS_W'(BUFFER_DIGITS) : max_digits_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_digits_reg <= MAX_DIGITS_RESET;
        end
        else if (psel && penable && pwrite && pready && (paddr == ADDR_MAX_DIGITS))
        begin
            max_digits_reg <= pwdata[DIGITS_W-1:0];
        end
    end

    fdmp_parser u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .rx_byte     (s_tdata[RX_BYTE_W-1:0]),
        .digit_limit (digit_limit),
        .out_free    (out_free),
        .res_valid   (res_valid),
        .res         (res),
        .status      (status)
    );

    fdmp_result_reg u_result (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .out_free  (out_free),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    a_count_in_limit: assert property (@(posedge clk) disable iff (!rst_n)
        status.digit_count <= DIGITS_W'(BUFFER_DIGITS))
        else $error("Digit count exceeds the buffer size.");

    a_idle_count_clear: assert property (@(posedge clk) disable iff (!rst_n)
        !status.in_frame |-> (status.digit_count == '0))
        else $error("Digit count not cleared outside a frame.");

    a_result_digits: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |=> (m_tvalid && (m_tdata[16:14] != '0) &&
                       (m_tdata[16:14] <= DIGITS_W'(BUFFER_DIGITS))))
        else $error("Result transaction carries an invalid digit count.");

    a_frame_closes: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |=> ((status.digit_count == '0) ||
                       ($past(s_tready && s_tvalid) && ($past(s_tdata) == CH_START))))
        else $error("Frame state not cleared after a result.");

endmodule : framed_decimal_message_parser_core
`default_nettype wire
